// ===== hdl/sobel_edge_magnitude_3x3_assert.svh =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude: assertion macros
// Shared concurrent assertion forms, clocked with reset disable.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_ASSERT_SVH

// same-cycle implication
`define SEM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sobel edge magnitude: check failed");

// next-cycle implication
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sobel edge magnitude: check failed");

`endif

// ===== hdl/sem_pkg.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude package
// Sizes, codes, shared types and the delay line address helper.
// ---------------------------------------------------------------------------
package sem_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int DEPTH      = 2 * MAX_WIDTH + 3;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CFG_W      = 11;
   localparam int PIX_W      = 8;
   localparam int LVL_W      = 3;
   localparam int GRAD_W     = 6;
   localparam int MAG_W      = 6;
   localparam int SQ_W       = 11;
   localparam int RGB_W      = 8;
   localparam int OUT_W      = 2 * GRAD_W + MAG_W + LVL_W + RGB_W;
   localparam int OUT_BYTES  = (OUT_W + 7) / 8;
   localparam int READ_STEPS = 3;
   localparam int STEP_W     = 2;
   localparam int BIT_W      = $clog2(MAG_W);

   localparam logic [LVL_W-1:0] LEVEL_MAX = '1;

   typedef enum logic {
      CSR_LINE_WIDTH  = 1'b0,
      CSR_LEVEL_SHIFT = 1'b1
   } sem_csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_GRAD,
      S_SQ,
      S_ROOT,
      S_EMIT
   } sem_state_type;

   typedef struct packed {
      logic             valid;
      logic [LVL_W-1:0] level;
   } sem_item_type;

   typedef struct packed {
      logic [CFG_W-1:0] line_width;
      logic [LVL_W-1:0] level_shift;
   } sem_cfg_type;

   // address of the entry a given age behind the write pointer
   function automatic logic [ADDR_W-1:0] tap_addr(input logic [ADDR_W-1:0] pos,
                                                 input logic [ADDR_W-1:0] age);
      logic [ADDR_W:0] diff;
      diff = {1'b0, pos} - {1'b0, age};
      if (diff[ADDR_W]) begin
         tap_addr = diff[ADDR_W-1:0] + ADDR_W'(DEPTH);
      end else begin
         tap_addr = diff[ADDR_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/sem_front.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude front end
// Accepts pixels, keeps the intensity bits and queues them for the back end.
// ---------------------------------------------------------------------------
module sem_front
   import sem_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [PIX_W-1:0] req_tdata,   // [7:0] pixel
   output sem_item_type     item,
   input  logic             item_pop
);

   logic [LVL_W-1:0] queue_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;

   assign item.valid = (count_ff != 2'd0);
   assign item.level = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (item_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, item_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // intensity is the top three bits of the byte
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= req_tdata[PIX_W-1 -: LVL_W];
      end
   end

endmodule

// ===== hdl/sem_back.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude back end
// Delay line memory, window reads, Sobel sums, square root and result slot.
// ---------------------------------------------------------------------------
module sem_back
   import sem_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sem_cfg_type       cfg,
   input  sem_item_type      item,
   output logic              item_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_W-1:0]  rsp_data
);

   sem_state_type state_ff, state_in;

   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [LVL_W-1:0]  cur_ff, hist1_ff, hist2_ff;

   logic [LVL_W-1:0]  mem [DEPTH];
   logic [LVL_W-1:0]  rd0_ff, rd1_ff;
   logic              ok0_ff, ok1_ff;
   logic              cap_en_ff;
   logic [STEP_W-1:0] cap_sel_ff;

   logic [LVL_W-1:0]  tl_ff, t_ff, tr_ff, l_ff, r_ff;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [MAG_W-1:0]  root_ff;
   logic [BIT_W-1:0]  root_bit_ff;

   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_data_ff;
   logic              load;

   logic [ADDR_W-1:0] w_eff;
   logic [ADDR_W-1:0] age0, age1;
   logic [ADDR_W-1:0] raddr0, raddr1;
   logic              ok0, ok1;

   logic signed [GRAD_W:0] gx, gy;
   logic signed [2*GRAD_W-1:0] px, py;
   logic [2*GRAD_W-1:0] psum;
   logic [MAG_W-1:0]    trial;
   logic [2*MAG_W-1:0]  trial_sq;
   logic [MAG_W-1:0]    lvl_wide;
   logic [LVL_W-1:0]    lvl;
   logic [RGB_W-1:0]    rgb;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // clamp the row width into 1..MAX_WIDTH
   always_comb begin
      if (cfg.line_width == '0) begin
         w_eff = ADDR_W'(1);
      end else if (ADDR_W'(cfg.line_width) > ADDR_W'(MAX_WIDTH)) begin
         w_eff = ADDR_W'(MAX_WIDTH);
      end else begin
         w_eff = ADDR_W'(cfg.line_width);
      end
   end

   // paired window reads: top left and top, then top right and left, then right
   always_comb begin
      case (step_ff)
         STEP_W'(0): begin
            age0 = (w_eff << 1) + ADDR_W'(2);
            age1 = (w_eff << 1) + ADDR_W'(1);
         end
         STEP_W'(1): begin
            age0 = w_eff << 1;
            age1 = w_eff + ADDR_W'(2);
         end
         default: begin
            age0 = w_eff;
            age1 = w_eff;
         end
      endcase
      raddr0 = tap_addr(pos_ff, age0);
      raddr1 = tap_addr(pos_ff, age1);
      // entries that no pixel has reached yet read as zero
      ok0    = CNT_W'(age0) < cnt_ff;
      ok1    = CNT_W'(age1) < cnt_ff;
   end

   always_comb begin
      pos_in = (pos_ff == ADDR_W'(DEPTH - 1)) ? '0 : pos_ff + ADDR_W'(1);
      cnt_in = (cnt_ff == CNT_W'(DEPTH)) ? cnt_ff : cnt_ff + CNT_W'(1);
   end

   // Sobel sums, bottom row from the short history registers
   always_comb begin
      gx = $signed({4'd0, tl_ff}) - $signed({4'd0, tr_ff})
         + ($signed({4'd0, l_ff}) <<< 1) - ($signed({4'd0, r_ff}) <<< 1)
         + $signed({4'd0, hist2_ff}) - $signed({4'd0, cur_ff});
      gy = $signed({4'd0, tl_ff}) + ($signed({4'd0, t_ff}) <<< 1)
         + $signed({4'd0, tr_ff}) - $signed({4'd0, hist2_ff})
         - ($signed({4'd0, hist1_ff}) <<< 1) - $signed({4'd0, cur_ff});
   end

   always_comb begin
      px       = gx_ff * gx_ff;
      py       = gy_ff * gy_ff;
      psum     = 12'(px) + 12'(py);
      trial    = root_ff | (MAG_W'(1) << root_bit_ff);
      trial_sq = trial * trial;
      lvl_wide = root_ff >> cfg.level_shift;
      lvl      = (lvl_wide > MAG_W'(LEVEL_MAX)) ? LEVEL_MAX : lvl_wide[LVL_W-1:0];
      rgb      = {lvl, lvl, lvl[LVL_W-1:1]};
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      item_pop = 1'b0;
      load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (item.valid) begin
               item_pop = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(READ_STEPS - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_GRAD;
         S_GRAD:  state_in = S_SQ;
         S_SQ:    state_in = S_ROOT;
         S_ROOT: begin
            if (root_bit_ff == '0) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         cur_ff       <= '0;
         hist1_ff     <= '0;
         hist2_ff     <= '0;
         cap_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         cap_en_ff <= (state_ff == S_READ);
         if (item_pop) begin
            pos_ff   <= pos_in;
            cnt_ff   <= cnt_in;
            cur_ff   <= item.level;
            hist1_ff <= cur_ff;
            hist2_ff <= hist1_ff;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // delay line memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (item_pop) begin
         mem[pos_in] <= item.level;
      end
      rd0_ff <= mem[raddr0];
      rd1_ff <= mem[raddr1];
   end

   always_ff @(posedge clock) begin
      ok0_ff     <= ok0;
      ok1_ff     <= ok1;
      cap_sel_ff <= step_ff;
      if (cap_en_ff) begin
         case (cap_sel_ff)
            STEP_W'(0): begin
               tl_ff <= ok0_ff ? rd0_ff : '0;
               t_ff  <= ok1_ff ? rd1_ff : '0;
            end
            STEP_W'(1): begin
               tr_ff <= ok0_ff ? rd0_ff : '0;
               l_ff  <= ok1_ff ? rd1_ff : '0;
            end
            default: r_ff <= ok0_ff ? rd0_ff : '0;
         endcase
      end
      if (state_ff == S_GRAD) begin
         gx_ff <= gx[GRAD_W-1:0];
         gy_ff <= gy[GRAD_W-1:0];
      end
      if (state_ff == S_SQ) begin
         sq_ff       <= psum[SQ_W-1:0];
         root_ff     <= '0;
         root_bit_ff <= BIT_W'(MAG_W - 1);
      end
      // one result bit per cycle, most significant first
      if (state_ff == S_ROOT) begin
         if (trial_sq <= {1'b0, sq_ff}) begin
            root_ff <= trial;
         end
         root_bit_ff <= root_bit_ff - BIT_W'(1);
      end
      if (load) begin
         rsp_data_ff <= {rgb, lvl, root_ff, gy_ff, gx_ff};
      end
   end

`include "sobel_edge_magnitude_3x3_assert.svh"

   `SEM_ASSERT_NOW(a_pop_idle, clock, reset, item_pop, state_ff == S_IDLE)
   `SEM_ASSERT_NEXT(a_pop_reads, clock, reset, item_pop, state_ff == S_READ && step_ff == '0)
   `SEM_ASSERT_NOW(a_root_range, clock, reset, load, root_ff <= MAG_W'(39))
   `SEM_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1,
                   cnt_ff <= CNT_W'(DEPTH) && pos_ff < ADDR_W'(DEPTH))
   `SEM_ASSERT_NOW(a_load_slot, clock, reset, load, !rsp_valid_ff || rsp_tready)

endmodule

// ===== hdl/sobel_edge_magnitude_3x3.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude 3x3
// Raster pixel stream in, Sobel gradients, magnitude and edge level out.
// ---------------------------------------------------------------------------
// For each pixel the back end writes the pixel into the delay line memory,
// reads five window taps through the memory's two read ports, forms the
// sums and the squared sum, then runs a six-step bit-serial square root
// before the result slot is loaded. A two-entry queue in front accepts
// pixels while the back end works. Window taps that no pixel has reached
// yet read as zero, tracked by a fill count, so no clearing pass follows
// reset.
module sobel_edge_magnitude_3x3
   import sem_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIX_W-1:0]       req_tdata,   // [7:0] pixel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [5:0] grad_x, [11:6] grad_y, [17:12] magnitude, [20:18] edge_level,
   // [28:21] rgb_out, [31:29] zero
   output logic [8*OUT_BYTES-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [CFG_W-1:0]       csr_wdata
);

   logic [CFG_W-1:0] line_width_ff;
   logic [LVL_W-1:0] level_shift_ff;
   sem_cfg_type      cfg;
   sem_item_type     item;
   logic             item_pop;
   logic [OUT_W-1:0] rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= CFG_W'(640);
         level_shift_ff <= LVL_W'(2);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINE_WIDTH:  line_width_ff  <= csr_wdata;
            CSR_LEVEL_SHIFT: level_shift_ff <= csr_wdata[LVL_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.line_width  = line_width_ff;
   assign cfg.level_shift = level_shift_ff;
   assign rsp_tdata       = {(8*OUT_BYTES-OUT_W)'(0), rsp_data};

   sem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item       (item),
      .item_pop   (item_pop)
   );

   sem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

endmodule
